/* sv/es2cal_pkg.sv */
// Constants and the month table shared by the epoch seconds to calendar converter.
package es2cal_pkg;

  localparam int NUM_STAGES = 7;

  // Days from 1600-03-01 to 1970-01-01, and days in one 400-year cycle.
  localparam logic [17:0] DAYS_1600_TO_1970 = 18'd135080;
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [17:0] LAST_DAY_OF_ERA = 18'd146096;
  localparam logic [17:0] DAYS_PER_CENTURY = 18'd36524;
  localparam logic [11:0] BASE_YEAR = 12'd1600;
  localparam logic [11:0] YEARS_PER_ERA = 12'd400;

  // A year that starts in March reaches January at this month index.
  localparam logic [3:0] MP_JANUARY = 4'd10;

  // Reciprocals ceil(2^k / d); each is exact over the full range of its operand.
  localparam logic [25:0] DIV675_MULT = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
  localparam logic [18:0] DIV1460_MULT = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] DIV365_MULT = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [11:0] DIV153_MULT = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [17:0] DIV3600_MULT = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] DIV60_MULT = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

  // First day of each month within a year that starts on March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0: res = 9'd0;
      4'd1: res = 9'd31;
      4'd2: res = 9'd61;
      4'd3: res = 9'd92;
      4'd4: res = 9'd122;
      4'd5: res = 9'd153;
      4'd6: res = 9'd184;
      4'd7: res = 9'd214;
      4'd8: res = 9'd245;
      4'd9: res = 9'd275;
      4'd10: res = 9'd306;
      4'd11: res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

/* sv/epoch_seconds_to_calendar.sv */
// Pipelined conversion of epoch seconds to Gregorian date and time of day.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_epoch_seconds[31:0]
//   out_    | output    | out_valid/out_stall| out_year, out_month, out_day,
//           |           |                    | out_hour, out_minute, out_second
//
// One word is accepted per cycle while in_stall is low; each result passes through
// the seven register stages of the divide and calendar datapath.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on the output holds the last full stage, and empty stages ahead of
// it keep filling, so the input stalls only when every stage holds a word.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);

  logic [es2cal_pkg::NUM_STAGES:1] vld_r;
  logic [es2cal_pkg::NUM_STAGES:1] en;

  always_comb begin
    en[es2cal_pkg::NUM_STAGES] = !vld_r[es2cal_pkg::NUM_STAGES] || !out_stall;
    for (int k = es2cal_pkg::NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k + 1];
    end
  end

  assign in_stall = !en[1];
  assign out_valid = vld_r[es2cal_pkg::NUM_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= es2cal_pkg::NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k - 1];
        end
      end
    end
  end

  // Stage 1: day count through seconds / 128 / 675.
  logic [50:0] s1_prod;
  logic [50:0] p1_prod_r;
  logic [16:0] p1_lo_r;

  assign s1_prod = 51'(in_epoch_seconds[31:7]) * 51'(es2cal_pkg::DIV675_MULT);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1_prod_r <= s1_prod;
      p1_lo_r <= in_epoch_seconds[16:0];
    end
  end

  // Stage 2: seconds of the day, and the day within its 400-year cycle.
  logic [15:0] s2_days;
  logic [32:0] s2_dsec;
  logic [17:0] s2_z;
  logic        s2_era;
  logic [16:0] p2_sod_r;
  logic        p2_era_r;
  logic [17:0] p2_doe_r;

  always_comb begin
    s2_days = p1_prod_r[50:35];
    s2_dsec = 33'(s2_days) * 33'd86400;
    s2_z = 18'(s2_days) + es2cal_pkg::DAYS_1600_TO_1970;
    s2_era = s2_z >= es2cal_pkg::DAYS_PER_ERA;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2_sod_r <= p1_lo_r - s2_dsec[16:0];
      p2_era_r <= s2_era;
      p2_doe_r <= s2_era ? s2_z - es2cal_pkg::DAYS_PER_ERA : s2_z;
    end
  end

  // Stage 3: leap corrections of the cycle day, and the hour.
  logic [36:0] s3_prod;
  logic [34:0] s3_hprod;
  logic [2:0]  s3_cent;
  logic [17:0] p3_doe_r;
  logic        p3_era_r;
  logic [6:0]  p3_a_r;
  logic [2:0]  p3_b_r;
  logic        p3_c_r;
  logic [16:0] p3_sod_r;
  logic [4:0]  p3_hour_r;

  always_comb begin
    s3_prod = 37'(p2_doe_r) * 37'(es2cal_pkg::DIV1460_MULT);
    s3_hprod = 35'(p2_sod_r) * 35'(es2cal_pkg::DIV3600_MULT);
    s3_cent = 3'(p2_doe_r >= es2cal_pkg::DAYS_PER_CENTURY)
            + 3'(p2_doe_r >= 18'd73048)
            + 3'(p2_doe_r >= 18'd109572)
            + 3'(p2_doe_r >= es2cal_pkg::LAST_DAY_OF_ERA);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p3_doe_r <= p2_doe_r;
      p3_era_r <= p2_era_r;
      p3_a_r <= s3_prod[35:29];
      p3_b_r <= s3_cent;
      p3_c_r <= p2_doe_r == es2cal_pkg::LAST_DAY_OF_ERA;
      p3_sod_r <= p2_sod_r;
      p3_hour_r <= s3_hprod[33:29];
    end
  end

  // Stage 4: year of the cycle, and the seconds left within the hour.
  logic [17:0] s4_n;
  logic [36:0] s4_prod;
  logic [16:0] s4_hsec;
  logic [16:0] s4_rem;
  logic [17:0] p4_doe_r;
  logic        p4_era_r;
  logic [8:0]  p4_yoe_r;
  logic [4:0]  p4_hour_r;
  logic [11:0] p4_rem_r;

  always_comb begin
    s4_n = p3_doe_r - 18'(p3_a_r) + 18'(p3_b_r) - 18'(p3_c_r);
    s4_prod = 37'(s4_n) * 37'(es2cal_pkg::DIV365_MULT);
    s4_hsec = 17'(p3_hour_r) * 17'd3600;
    s4_rem = p3_sod_r - s4_hsec;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      p4_doe_r <= p3_doe_r;
      p4_era_r <= p3_era_r;
      p4_yoe_r <= s4_prod[35:27];
      p4_hour_r <= p3_hour_r;
      p4_rem_r <= s4_rem[11:0];
    end
  end

  // Stage 5: day of the March-based year, and the minute.
  logic [1:0]  s5_cent;
  logic [17:0] s5_ystart;
  logic [17:0] s5_doy;
  logic [24:0] s5_mprod;
  logic        p5_era_r;
  logic [8:0]  p5_yoe_r;
  logic [8:0]  p5_doy_r;
  logic [4:0]  p5_hour_r;
  logic [11:0] p5_rem_r;
  logic [5:0]  p5_min_r;

  always_comb begin
    s5_cent = 2'(p4_yoe_r >= 9'd100) + 2'(p4_yoe_r >= 9'd200) + 2'(p4_yoe_r >= 9'd300);
    s5_ystart = 18'(p4_yoe_r) * 18'd365 + 18'(p4_yoe_r[8:2]) - 18'(s5_cent);
    s5_doy = p4_doe_r - s5_ystart;
    s5_mprod = 25'(p4_rem_r) * 25'(es2cal_pkg::DIV60_MULT);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p5_era_r <= p4_era_r;
      p5_yoe_r <= p4_yoe_r;
      p5_doy_r <= s5_doy[8:0];
      p5_hour_r <= p4_hour_r;
      p5_rem_r <= p4_rem_r;
      p5_min_r <= s5_mprod[23:18];
    end
  end

  // Stage 6: month index counted from March, and the second.
  logic [10:0] s6_x;
  logic [22:0] s6_prod;
  logic [11:0] s6_sec;
  logic        p6_era_r;
  logic [8:0]  p6_yoe_r;
  logic [8:0]  p6_doy_r;
  logic [3:0]  p6_mp_r;
  logic [4:0]  p6_hour_r;
  logic [5:0]  p6_min_r;
  logic [5:0]  p6_sec_r;

  always_comb begin
    s6_x = 11'(p5_doy_r) * 11'd5 + 11'd2;
    s6_prod = 23'(s6_x) * 23'(es2cal_pkg::DIV153_MULT);
    s6_sec = p5_rem_r - 12'(p5_min_r) * 12'd60;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      p6_era_r <= p5_era_r;
      p6_yoe_r <= p5_yoe_r;
      p6_doy_r <= p5_doy_r;
      p6_mp_r <= s6_prod[22:19];
      p6_hour_r <= p5_hour_r;
      p6_min_r <= p5_min_r;
      p6_sec_r <= s6_sec[5:0];
    end
  end

  // Stage 7: calendar month, day and year, with the time of day, into the output register.
  logic        s7_jan_feb;
  logic [8:0]  s7_day;
  logic [11:0] s7_year;
  logic [3:0]  s7_month;

  always_comb begin
    s7_jan_feb = p6_mp_r >= es2cal_pkg::MP_JANUARY;
    s7_day = p6_doy_r - es2cal_pkg::month_start(p6_mp_r) + 9'd1;
    s7_month = s7_jan_feb ? p6_mp_r - 4'd9 : p6_mp_r + 4'd3;
    s7_year = es2cal_pkg::BASE_YEAR
            + (p6_era_r ? es2cal_pkg::YEARS_PER_ERA : 12'd0)
            + 12'(p6_yoe_r) + 12'(s7_jan_feb);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_year <= s7_year;
      out_month <= s7_month;
      out_day <= s7_day[4:0];
      out_hour <= p6_hour_r;
      out_minute <= p6_min_r;
      out_second <= p6_sec_r;
    end
  end

endmodule

/* dv/epoch_seconds_to_calendar_tb.sv */
// Testbench for the epoch seconds to calendar converter with a predicting scoreboard.
`timescale 1ns / 100ps

typedef struct packed {
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
} civil_time_t;

class calendar_scoreboard;
  civil_time_t dates_due[$];
  int unsigned errors;
  int unsigned checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  function bit leap_year(longint unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function civil_time_t civil_from_seconds(logic [31:0] stamp);
    civil_time_t res;
    longint unsigned t;
    longint unsigned days;
    longint unsigned yr;
    longint unsigned len;
    int unsigned mon;
    int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    t = stamp;
    res.second = 6'(t % 60);
    t = t / 60;
    res.minute = 6'(t % 60);
    t = t / 60;
    res.hour = 5'(t % 24);
    days = t / 24;
    yr = 1970 + 400 * (days / 146097);
    days = days % 146097;
    forever begin
      len = leap_year(yr) ? 366 : 365;
      if (days < len) break;
      days -= len;
      yr++;
    end
    mon = 1;
    while (mon < 12) begin
      len = month_days[mon - 1];
      if (mon == 2 && leap_year(yr)) len = 29;
      if (days < len) break;
      days -= len;
      mon++;
    end
    res.year = 12'(yr);
    res.month = 4'(mon);
    res.day = 5'(days + 1);
    return res;
  endfunction

  function void note_word(logic [31:0] stamp);
    dates_due.push_back(civil_from_seconds(stamp));
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(civil_time_t got);
    civil_time_t want;
    if (dates_due.size() == 0) begin
      $display("%0t: unexpected result word %0d-%0d-%0d %0d:%0d:%0d", $time,
               got.year, got.month, got.day, got.hour, got.minute, got.second);
      errors++;
      return;
    end
    want = dates_due.pop_front();
    checked++;
    compare_field("year", want.year, got.year);
    compare_field("month", want.month, got.month);
    compare_field("day", want.day, got.day);
    compare_field("hour", want.hour, got.hour);
    compare_field("minute", want.minute, got.minute);
    compare_field("second", want.second, got.second);
  endfunction

  function int unsigned pending();
    return dates_due.size();
  endfunction
endclass

module epoch_seconds_to_calendar_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_epoch_seconds = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  calendar_scoreboard sb = new();
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;
  int unsigned directed_count = 0;

  epoch_seconds_to_calendar dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_epoch_seconds);
      if (out_valid && !out_stall)
        sb.check_result('{out_year, out_month, out_day, out_hour, out_minute, out_second});
    end
  end

  // The receiver switches between free running, light, heavy and periodic stalling.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run <= $urandom_range(5, 60);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_run % 8 < 5);
    endcase
  end

  task automatic send_word(input logic [31:0] stamp);
    in_valid <= 1'b1;
    in_epoch_seconds <= stamp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  initial begin
    logic [31:0] directed [] = '{
      32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000, 32'd68169600, 32'd951782400, 32'd978220800,
      32'd4107542399, 32'd4107542400, 32'd2147483647, 32'd2147483648,
      32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555, 32'd1234567890
    };
    int unsigned day_offsets [8] = '{0, 30, 31, 58, 59, 60, 364, 365};
    int unsigned burst;
    int unsigned sent;
    longint unsigned yr;
    longint unsigned stamp;
    longint unsigned span;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_word(directed[i]);
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 4));
    end
    directed_count = directed.size();

    sent = 0;
    while (sent < 1600) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: stamp = $urandom;
          4, 5, 6: begin
            // Around a random midnight, or at a random time of that day.
            stamp = longint'($urandom_range(0, 49710)) * 86400;
            case ($urandom_range(0, 3))
              0: stamp += 0;
              1: stamp += 86399;
              2: stamp += 86398 + $urandom_range(0, 2);
              default: stamp += $urandom_range(0, 86399);
            endcase
          end
          default: begin
            // Near the start of a year, the end of February or the end of a year.
            yr = $urandom_range(1970, 2106);
            span = 365 * (yr - 1970) + ((yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400)
                   - (1969 / 4 - 1969 / 100 + 1969 / 400);
            span += day_offsets[$urandom_range(0, 7)];
            stamp = span * 86400;
            case ($urandom_range(0, 2))
              0: stamp += 0;
              1: stamp += 86399;
              default: stamp += $urandom_range(0, 86399);
            endcase
          end
        endcase
        if (stamp > 64'hFFFFFFFF) stamp = 64'hFFFFFFFF - $urandom_range(0, 100000);
        send_word(stamp[31:0]);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (3 * es2cal_pkg::NUM_STAGES) @(posedge clk);

    $display("Checked %0d converted timestamps, %0d of them directed corner cases,",
             sb.checked, directed_count);
    $display("with random sender gaps and receiver stalls throughout.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
